@@ rtl/quad_convexify_split_macros.svh @@
// Assertion helpers shared by the RTL; both sample on clock and stand down in reset.
`ifndef QUAD_CONVEXIFY_SPLIT_MACROS_SVH
`define QUAD_CONVEXIFY_SPLIT_MACROS_SVH

// Same-cycle implication.
`define QCS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/qcs_pkg.sv @@
package qcs_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int DET_WIDTH   = PROD_WIDTH + 1;
   localparam int CPROD_WIDTH = 2 * COORD_WIDTH;
   localparam int CONST_WIDTH = CPROD_WIDTH + 1;
   localparam int NUM_WIDTH   = 3 * COORD_WIDTH + 3;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_SLOTS   = 6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [DET_WIDTH-1:0]   det_type;
   typedef logic signed [CPROD_WIDTH-1:0] cprod_type;
   typedef logic signed [CONST_WIDTH-1:0] const_type;
   typedef logic signed [NUM_WIDTH-1:0]   num_type;
   typedef logic [1:0]                    corner_idx_type;
   typedef logic [2:0]                    slot_cnt_type;

   typedef enum logic [1:0] {
      STATUS_CONVEX    = 2'd0,
      STATUS_ONE_THREE = 2'd1,
      STATUS_TWO_TWO   = 2'd2,
      STATUS_ERROR     = 2'd3
   } status_type;

   typedef struct packed {
      coord_type corner0_x;
      coord_type corner0_y;
      coord_type corner1_x;
      coord_type corner1_y;
      coord_type corner2_x;
      coord_type corner2_y;
      coord_type corner3_x;
      coord_type corner3_y;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       piece;
      logic [1:0] corner_slot;
      coord_type  out_x;
      coord_type  out_y;
      logic       last_flag;
   } rsp_type;

   // Classified quad: emission order and the corners it needs.
   typedef struct packed {
      status_type                      status;
      slot_cnt_type                    last_idx;
      corner_idx_type [NUM_SLOTS-1:0]  pick;
      corner_idx_type                  split_k;
      coord_type [NUM_CORNERS-1:0]     px;
      coord_type [NUM_CORNERS-1:0]     py;
   } quad_type;

   // Divider operands: magnitudes, signs, overflow flags and a zero-determinant flag.
   typedef struct packed {
      logic [NUM_WIDTH-1:0] num_x;
      logic [NUM_WIDTH-1:0] num_y;
      logic [DET_WIDTH-1:0] den;
      logic                 neg_x;
      logic                 neg_y;
      logic                 ovf_x;
      logic                 ovf_y;
      logic                 det_zero;
   } div_req_type;

   typedef struct packed {
      div_req_type            op;
      logic [COORD_WIDTH-1:0] quo_x;
      logic [COORD_WIDTH-1:0] quo_y;
   } div_state_type;

   function automatic diff_type sub_coord(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   function automatic prod_type mul_diff(diff_type a, diff_type b);
      return prod_type'(a) * prod_type'(b);
   endfunction

   function automatic cprod_type mul_coord(coord_type a, coord_type b);
      return cprod_type'(a) * cprod_type'(b);
   endfunction

   // Upper signed slice of a constant term.
   function automatic diff_type const_hi(const_type c);
      return diff_type'(c[CONST_WIDTH-1:COORD_WIDTH]);
   endfunction

   // Lower unsigned slice, zero-extended to a signed operand.
   function automatic diff_type const_lo(const_type c);
      return diff_type'({1'b0, c[COORD_WIDTH-1:0]});
   endfunction

endpackage

@@ rtl/quad_convexify_split.sv @@
// Quadrilateral convexity test and triangle split.
//
// Input: drive req_item with four corners and raise start; the quad is taken
// at a rising edge where start is high and busy is low.
// Output: one vertex per cycle on rsp_item, marked by rsp_valid for exactly one
// cycle; last_flag marks the final vertex of each quad. Convex quads give four
// vertices, split quads six, rejected quads a single error result.
// Pipeline: 39 register stages (5 classify stages, 8 intersection stages,
// 24 quotient stages, one saturation stage, one output register), the first
// written at the accepting edge; the first vertex of a quad is on rsp_item
// once the output register holds it.
// Throughput: a quad may enter every cycle until the pipeline backs up; the
// output port then sets the pace, since one vertex leaves per cycle.
// Backpressure: the result side cannot stall. When the last pipeline stage
// holds a quad the output stage cannot take yet, the whole pipeline holds and
// busy goes high.
// Reset: synchronous; clears all stage valids and the output stage.
`include "quad_convexify_split_macros.svh"

module quad_convexify_split (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qcs_pkg::req_type  req_item,
   output logic              rsp_valid,
   output qcs_pkg::rsp_type  rsp_item
);

   logic                 adv;
   logic                 front_valid, isect_valid, div_valid, load;
   qcs_pkg::quad_type    front_quad, isect_quad, div_quad;
   qcs_pkg::div_req_type isect_op;
   qcs_pkg::coord_type   div_x, div_y;
   logic                 div_det_zero;

   // Advance every stage unless the finished quad waits on the output stage.
   assign adv  = !div_valid || load;
   assign busy = !adv;

   // Sign each corner turn, classify, pick the vertex order.
   qcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (start),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_quad  (front_quad)
   );

   // Build the crossing-point numerators and determinant.
   qcs_isect u_isect (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_quad   (front_quad),
      .out_valid (isect_valid),
      .out_quad  (isect_quad),
      .out_op    (isect_op)
   );

   // Divide exactly, truncate and saturate.
   qcs_div u_div (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (isect_valid),
      .in_quad      (isect_quad),
      .in_op        (isect_op),
      .out_valid    (div_valid),
      .out_quad     (div_quad),
      .out_x        (div_x),
      .out_y        (div_y),
      .out_det_zero (div_det_zero)
   );

   // Step out one vertex per cycle.
   qcs_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (div_valid),
      .in_quad     (div_quad),
      .in_x        (div_x),
      .in_y        (div_y),
      .in_det_zero (div_det_zero),
      .load        (load),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   // A quad's vertices leave without gaps.
   `QCS_ASSERT_NEXT(a_vertices_back_to_back, rsp_valid && !rsp_item.last_flag, rsp_valid,
                    "vertex run of a quad broken")
   // Holding off input only happens while vertices are leaving.
   `QCS_ASSERT_SAME(a_busy_only_when_emitting, busy, rsp_valid,
                    "busy without output activity")
   // An error is a single zeroed result.
   `QCS_ASSERT_SAME(a_error_single,
                    rsp_valid && rsp_item.status == qcs_pkg::STATUS_ERROR,
                    rsp_item.last_flag && rsp_item.out_x == '0 && rsp_item.out_y == '0,
                    "malformed error result")
   // The second triangle exists only for split quads.
   `QCS_ASSERT_SAME(a_piece_only_split, rsp_valid && rsp_item.piece,
                    rsp_item.status == qcs_pkg::STATUS_ONE_THREE ||
                    rsp_item.status == qcs_pkg::STATUS_TWO_TWO,
                    "second triangle on unsplit quad")

endmodule

@@ rtl/qcs_front.sv @@
module qcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  qcs_pkg::req_type  in_item,
   output logic              out_valid,
   output qcs_pkg::quad_type out_quad
);

   localparam int NC = qcs_pkg::NUM_CORNERS;

   logic [4:0] valid_ff;

   qcs_pkg::coord_type in_x [NC];
   qcs_pkg::coord_type in_y [NC];
   qcs_pkg::coord_type cx_ff [4][NC];
   qcs_pkg::coord_type cy_ff [4][NC];
   qcs_pkg::diff_type  ax_ff [NC];
   qcs_pkg::diff_type  by_ff [NC];
   qcs_pkg::diff_type  bx_ff [NC];
   qcs_pkg::diff_type  ay_ff [NC];
   qcs_pkg::prod_type  pa_ff [NC];
   qcs_pkg::prod_type  pb_ff [NC];
   qcs_pkg::det_type   cross_w [NC];
   logic [NC-1:0]      pos_in, neg_in, pos_ff, neg_ff;
   qcs_pkg::quad_type  quad_in, quad_ff;

   logic [2:0]               npos, nneg;
   logic [NC-1:0]            lone_mask;
   logic                     lone_pos, has_pair, is_convex, is_lone, is_pair;
   qcs_pkg::corner_idx_type  k_lone, k_pair, k_e, k_f;

   always_comb begin
      in_x[0] = in_item.corner0_x;
      in_y[0] = in_item.corner0_y;
      in_x[1] = in_item.corner1_x;
      in_y[1] = in_item.corner1_y;
      in_x[2] = in_item.corner2_x;
      in_y[2] = in_item.corner2_y;
      in_x[3] = in_item.corner3_x;
      in_y[3] = in_item.corner3_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NC; i++) begin
            cx_ff[0][i] <= in_x[i];
            cy_ff[0][i] <= in_y[i];
            for (int s = 1; s < 4; s++) begin
               cx_ff[s][i] <= cx_ff[s-1][i];
               cy_ff[s][i] <= cy_ff[s-1][i];
            end
            ax_ff[i] <= qcs_pkg::sub_coord(cx_ff[0][(i+3)%NC], cx_ff[0][i]);
            by_ff[i] <= qcs_pkg::sub_coord(cy_ff[0][(i+1)%NC], cy_ff[0][i]);
            bx_ff[i] <= qcs_pkg::sub_coord(cx_ff[0][(i+1)%NC], cx_ff[0][i]);
            ay_ff[i] <= qcs_pkg::sub_coord(cy_ff[0][(i+3)%NC], cy_ff[0][i]);
            pa_ff[i] <= qcs_pkg::mul_diff(ax_ff[i], by_ff[i]);
            pb_ff[i] <= qcs_pkg::mul_diff(bx_ff[i], ay_ff[i]);
         end
         pos_ff  <= pos_in;
         neg_ff  <= neg_in;
         quad_ff <= quad_in;
      end
   end

   // Corner turn signs.
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         cross_w[i] = qcs_pkg::det_type'(pa_ff[i]) - qcs_pkg::det_type'(pb_ff[i]);
         neg_in[i]  = cross_w[i][qcs_pkg::DET_WIDTH-1];
         pos_in[i]  = !cross_w[i][qcs_pkg::DET_WIDTH-1] && (cross_w[i] != '0);
      end
   end

   // Classify and lay out the emission order.
   always_comb begin
      npos = '0;
      nneg = '0;
      for (int i = 0; i < NC; i++) begin
         npos = npos + {2'b00, pos_ff[i]};
         nneg = nneg + {2'b00, neg_ff[i]};
      end
      is_convex = (npos == 3'd4) || (nneg == 3'd4);
      is_lone   = ((npos == 3'd1) && (nneg == 3'd3)) || ((npos == 3'd3) && (nneg == 3'd1));
      is_pair   = (npos == 3'd2) && (nneg == 3'd2);
      lone_pos  = (npos == 3'd1);
      lone_mask = lone_pos ? pos_ff : neg_ff;

      k_lone = '0;
      for (int i = NC - 1; i >= 0; i--) begin
         if (lone_mask[i]) begin
            k_lone = qcs_pkg::corner_idx_type'(i);
         end
      end
      has_pair = 1'b0;
      k_pair   = '0;
      for (int i = NC - 1; i >= 0; i--) begin
         if (pos_ff[i] && pos_ff[(i+1)%NC]) begin
            has_pair = 1'b1;
            k_pair   = qcs_pkg::corner_idx_type'(i);
         end
      end
      k_e = lone_pos ? (k_lone + 2'd1) : (k_lone + 2'd3);
      k_f = lone_pos ? (k_lone + 2'd3) : (k_lone + 2'd1);

      quad_in.status   = qcs_pkg::STATUS_ERROR;
      quad_in.last_idx = '0;
      quad_in.pick     = '0;
      quad_in.split_k  = k_pair;
      for (int i = 0; i < NC; i++) begin
         quad_in.px[i] = cx_ff[3][i];
         quad_in.py[i] = cy_ff[3][i];
      end

      if (is_convex) begin
         quad_in.status   = qcs_pkg::STATUS_CONVEX;
         quad_in.last_idx = 3'd3;
         for (int i = 0; i < NC; i++) begin
            quad_in.pick[i] = pos_ff[0] ? qcs_pkg::corner_idx_type'(i)
                                        : qcs_pkg::corner_idx_type'(NC - 1 - i);
         end
      end else if (is_lone) begin
         quad_in.status   = qcs_pkg::STATUS_ONE_THREE;
         quad_in.last_idx = 3'd5;
         quad_in.pick[0]  = k_lone;
         quad_in.pick[1]  = k_lone + 2'd2;
         quad_in.pick[2]  = k_e;
         quad_in.pick[3]  = k_lone;
         quad_in.pick[4]  = k_f;
         quad_in.pick[5]  = k_lone + 2'd2;
      end else if (is_pair && has_pair) begin
         quad_in.status   = qcs_pkg::STATUS_TWO_TWO;
         quad_in.last_idx = 3'd5;
         quad_in.pick[0]  = k_pair;
         quad_in.pick[1]  = k_pair + 2'd1;
         quad_in.pick[3]  = k_pair + 2'd3;
         quad_in.pick[4]  = k_pair + 2'd2;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_quad  = quad_ff;

endmodule

@@ rtl/qcs_isect.sv @@
module qcs_isect (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  qcs_pkg::quad_type    in_quad,
   output logic                 out_valid,
   output qcs_pkg::quad_type    out_quad,
   output qcs_pkg::div_req_type out_op
);

   localparam int W     = qcs_pkg::COORD_WIDTH;
   localparam int NW    = qcs_pkg::NUM_WIDTH;
   localparam int DEPTH = 8;
   localparam int DX01  = 0;
   localparam int DY01  = 1;
   localparam int DX32  = 2;
   localparam int DY32  = 3;

   logic [DEPTH-1:0]   valid_ff;
   qcs_pkg::quad_type  quad_ff [DEPTH];

   qcs_pkg::coord_type qx_in [4];
   qcs_pkg::coord_type qy_in [4];
   qcs_pkg::coord_type qx_ff [4];
   qcs_pkg::coord_type qy_ff [4];
   qcs_pkg::diff_type  dd_ff [3][4];
   qcs_pkg::prod_type  deta_ff, detb_ff;
   qcs_pkg::cprod_type c1a_ff, c1b_ff, c2a_ff, c2b_ff;
   qcs_pkg::const_type c1_ff, c2_ff;
   qcs_pkg::det_type   det_ff [4];
   qcs_pkg::prod_type  part_ff [8];
   qcs_pkg::num_type   term_ff [4];
   qcs_pkg::num_type   nx_ff, ny_ff;
   logic [NW-1:0]      magx_ff, magy_ff;
   logic [qcs_pkg::DET_WIDTH-1:0] detmag_ff;
   logic               negx_ff, negy_ff, detz_ff;
   qcs_pkg::div_req_type op_ff;

   // Reorder the corners around the positive pair.
   always_comb begin
      qx_in[0] = in_quad.px[in_quad.split_k];
      qy_in[0] = in_quad.py[in_quad.split_k];
      qx_in[1] = in_quad.px[in_quad.split_k + 2'd3];
      qy_in[1] = in_quad.py[in_quad.split_k + 2'd3];
      qx_in[2] = in_quad.px[in_quad.split_k + 2'd1];
      qy_in[2] = in_quad.py[in_quad.split_k + 2'd1];
      qx_in[3] = in_quad.px[in_quad.split_k + 2'd2];
      qy_in[3] = in_quad.py[in_quad.split_k + 2'd2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quad_ff[0] <= in_quad;
         for (int s = 1; s < DEPTH; s++) begin
            quad_ff[s] <= quad_ff[s-1];
         end
         // edge vectors and reordered corners
         for (int i = 0; i < 4; i++) begin
            qx_ff[i] <= qx_in[i];
            qy_ff[i] <= qy_in[i];
         end
         dd_ff[0][DX01] <= qcs_pkg::sub_coord(qx_in[0], qx_in[1]);
         dd_ff[0][DY01] <= qcs_pkg::sub_coord(qy_in[0], qy_in[1]);
         dd_ff[0][DX32] <= qcs_pkg::sub_coord(qx_in[3], qx_in[2]);
         dd_ff[0][DY32] <= qcs_pkg::sub_coord(qy_in[3], qy_in[2]);
         for (int s = 1; s < 3; s++) begin
            for (int i = 0; i < 4; i++) begin
               dd_ff[s][i] <= dd_ff[s-1][i];
            end
         end
         // products
         deta_ff <= qcs_pkg::mul_diff(dd_ff[0][DX01], dd_ff[0][DY32]);
         detb_ff <= qcs_pkg::mul_diff(dd_ff[0][DX32], dd_ff[0][DY01]);
         c1a_ff  <= qcs_pkg::mul_coord(qx_ff[0], qy_ff[1]);
         c1b_ff  <= qcs_pkg::mul_coord(qx_ff[1], qy_ff[0]);
         c2a_ff  <= qcs_pkg::mul_coord(qx_ff[2], qy_ff[3]);
         c2b_ff  <= qcs_pkg::mul_coord(qx_ff[3], qy_ff[2]);
         // determinant and line constants
         det_ff[0] <= qcs_pkg::det_type'(deta_ff) - qcs_pkg::det_type'(detb_ff);
         c1_ff     <= qcs_pkg::const_type'(c1a_ff) - qcs_pkg::const_type'(c1b_ff);
         c2_ff     <= qcs_pkg::const_type'(c2a_ff) - qcs_pkg::const_type'(c2b_ff);
         for (int s = 1; s < 4; s++) begin
            det_ff[s] <= det_ff[s-1];
         end
         // split the wide products into halves
         part_ff[0] <= qcs_pkg::mul_diff(dd_ff[2][DX01], qcs_pkg::const_hi(c2_ff));
         part_ff[1] <= qcs_pkg::mul_diff(dd_ff[2][DX01], qcs_pkg::const_lo(c2_ff));
         part_ff[2] <= qcs_pkg::mul_diff(dd_ff[2][DX32], qcs_pkg::const_hi(c1_ff));
         part_ff[3] <= qcs_pkg::mul_diff(dd_ff[2][DX32], qcs_pkg::const_lo(c1_ff));
         part_ff[4] <= qcs_pkg::mul_diff(dd_ff[2][DY32], qcs_pkg::const_hi(c1_ff));
         part_ff[5] <= qcs_pkg::mul_diff(dd_ff[2][DY32], qcs_pkg::const_lo(c1_ff));
         part_ff[6] <= qcs_pkg::mul_diff(dd_ff[2][DY01], qcs_pkg::const_hi(c2_ff));
         part_ff[7] <= qcs_pkg::mul_diff(dd_ff[2][DY01], qcs_pkg::const_lo(c2_ff));
         for (int t = 0; t < 4; t++) begin
            term_ff[t] <= (qcs_pkg::num_type'(part_ff[2*t]) <<< W)
                        + qcs_pkg::num_type'(part_ff[2*t+1]);
         end
         nx_ff <= term_ff[0] + term_ff[1];
         ny_ff <= term_ff[2] + term_ff[3];
         // magnitudes and signs
         magx_ff   <= nx_ff[NW-1] ? (~nx_ff + 1'b1) : nx_ff;
         magy_ff   <= ny_ff[NW-1] ? (~ny_ff + 1'b1) : ny_ff;
         detmag_ff <= det_ff[3][qcs_pkg::DET_WIDTH-1] ? (~det_ff[3] + 1'b1) : det_ff[3];
         negx_ff   <= nx_ff[NW-1] ^ det_ff[3][qcs_pkg::DET_WIDTH-1];
         negy_ff   <= ny_ff[NW-1] ^ det_ff[3][qcs_pkg::DET_WIDTH-1];
         detz_ff   <= (det_ff[3] == '0);
         // quotient overflow check
         op_ff.num_x    <= magx_ff;
         op_ff.num_y    <= magy_ff;
         op_ff.den      <= detmag_ff;
         op_ff.neg_x    <= negx_ff;
         op_ff.neg_y    <= negy_ff;
         op_ff.ovf_x    <= magx_ff >= (NW'(detmag_ff) << W);
         op_ff.ovf_y    <= magy_ff >= (NW'(detmag_ff) << W);
         op_ff.det_zero <= detz_ff;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_quad  = quad_ff[DEPTH-1];
   assign out_op    = op_ff;

endmodule

@@ rtl/qcs_div.sv @@
module qcs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  qcs_pkg::quad_type    in_quad,
   input  qcs_pkg::div_req_type in_op,
   output logic                 out_valid,
   output qcs_pkg::quad_type    out_quad,
   output qcs_pkg::coord_type   out_x,
   output qcs_pkg::coord_type   out_y,
   output logic                 out_det_zero
);

   localparam int W  = qcs_pkg::COORD_WIDTH;
   localparam int NW = qcs_pkg::NUM_WIDTH;

   logic [W:0]             valid_ff;
   qcs_pkg::quad_type      quad_ff [W+1];
   qcs_pkg::div_state_type st_ff [W];
   qcs_pkg::coord_type     ix_ff, iy_ff;
   logic                   detz_ff;

   function automatic qcs_pkg::coord_type saturate(logic [W-1:0] q, logic neg, logic ovf);
      qcs_pkg::coord_type max_v, min_v;
      max_v = {1'b0, {(W-1){1'b1}}};
      min_v = {1'b1, {(W-1){1'b0}}};
      if (!neg) begin
         return (ovf || q[W-1]) ? max_v : q;
      end
      return (ovf || (q[W-1] && (|q[W-2:0]))) ? min_v : (~q + 1'b1);
   endfunction

   // One quotient bit per stage, most significant first.
   for (genvar s = 0; s < W; s++) begin : g_step
      localparam int BIT = W - 1 - s;
      qcs_pkg::div_state_type src, nxt;
      logic [NW-1:0]          den_sh;

      if (s == 0) begin : g_first
         always_comb begin
            src.op    = in_op;
            src.quo_x = '0;
            src.quo_y = '0;
         end
      end else begin : g_rest
         assign src = st_ff[s-1];
      end

      always_comb begin
         nxt    = src;
         den_sh = NW'(src.op.den) << BIT;
         if (src.op.num_x >= den_sh) begin
            nxt.op.num_x   = src.op.num_x - den_sh;
            nxt.quo_x[BIT] = 1'b1;
         end
         if (src.op.num_y >= den_sh) begin
            nxt.op.num_y   = src.op.num_y - den_sh;
            nxt.quo_y[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quad_ff[0] <= in_quad;
         for (int s = 1; s <= W; s++) begin
            quad_ff[s] <= quad_ff[s-1];
         end
         ix_ff   <= saturate(st_ff[W-1].quo_x, st_ff[W-1].op.neg_x, st_ff[W-1].op.ovf_x);
         iy_ff   <= saturate(st_ff[W-1].quo_y, st_ff[W-1].op.neg_y, st_ff[W-1].op.ovf_y);
         detz_ff <= st_ff[W-1].op.det_zero;
      end
   end

   assign out_valid    = valid_ff[W];
   assign out_quad     = quad_ff[W];
   assign out_x        = ix_ff;
   assign out_y        = iy_ff;
   assign out_det_zero = detz_ff;

endmodule

@@ rtl/qcs_emit.sv @@
module qcs_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qcs_pkg::quad_type  in_quad,
   input  qcs_pkg::coord_type in_x,
   input  qcs_pkg::coord_type in_y,
   input  logic               in_det_zero,
   output logic               load,
   output logic               rsp_valid,
   output qcs_pkg::rsp_type   rsp_item
);

   logic                  active_ff;
   qcs_pkg::slot_cnt_type cnt_ff, last_ff, last_in;
   qcs_pkg::status_type   status_ff, status_in;
   qcs_pkg::quad_type     quad_ff;
   qcs_pkg::coord_type    ix_ff, iy_ff;
   logic                  at_last, use_x;
   qcs_pkg::corner_idx_type corner;

   assign at_last = (cnt_ff == last_ff);
   assign load    = in_valid && (!active_ff || at_last);

   always_comb begin
      status_in = in_quad.status;
      last_in   = in_quad.last_idx;
      if (in_quad.status == qcs_pkg::STATUS_TWO_TWO && in_det_zero) begin
         status_in = qcs_pkg::STATUS_ERROR;
         last_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (load) begin
         active_ff <= 1'b1;
         cnt_ff    <= '0;
      end else if (active_ff && at_last) begin
         active_ff <= 1'b0;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         last_ff   <= last_in;
         quad_ff   <= in_quad;
         ix_ff     <= in_x;
         iy_ff     <= in_y;
      end
   end

   always_comb begin
      corner = quad_ff.pick[cnt_ff];
      use_x  = (status_ff == qcs_pkg::STATUS_TWO_TWO) && (cnt_ff == 3'd2 || cnt_ff == 3'd5);
      rsp_item.status      = status_ff;
      rsp_item.piece       = (status_ff != qcs_pkg::STATUS_CONVEX) && (cnt_ff >= 3'd3);
      rsp_item.corner_slot = rsp_item.piece ? 2'(cnt_ff - 3'd3) : cnt_ff[1:0];
      rsp_item.out_x       = use_x ? ix_ff : quad_ff.px[corner];
      rsp_item.out_y       = use_x ? iy_ff : quad_ff.py[corner];
      rsp_item.last_flag   = at_last;
      if (status_ff == qcs_pkg::STATUS_ERROR) begin
         rsp_item.out_x = '0;
         rsp_item.out_y = '0;
      end
   end

   assign rsp_valid = active_ff;

endmodule
